/* hdl/gtmc_pkg.sv */
// gtmc_pkg: shared types and constants of the generation-tagged memo cache
// no dependencies; imported by every module of the block but gtmc_ram
`timescale 1ns / 1ps

package gtmc_pkg;

  localparam int KEY_W = 64;
  localparam int VAL_W = 16;
  localparam int CNT_W = 32;

  typedef logic [1:0]       action_t;
  typedef logic [KEY_W-1:0] key_t;
  typedef logic [VAL_W-1:0] value_t;
  typedef logic [CNT_W-1:0] count_t;

  localparam action_t ACT_PROBE = 2'd0;
  localparam action_t ACT_FILL  = 2'd1;
  localparam action_t ACT_CLEAR = 2'd2;

  localparam count_t COUNT_MAX = {CNT_W{1'b1}};

  // one beat's effect on the statistics
  typedef struct packed {
    logic probe;
    logic hit;
    logic fill;
    logic clear;
  } stat_op_t;

endpackage

/* hdl/generation_tagged_memo_cache_unit.sv */
// generation_tagged_memo_cache_unit: top level of the direct-mapped memo cache
// depends on gtmc_pkg, gtmc_ram and gtmc_stats
`timescale 1ns / 1ps

// A direct-mapped memo cache of 2**INDEX_BITS entries, indexed by the low key
// bits. A beat is taken when start is high and busy is low; every beat gives
// exactly one result, shown for one cycle with out_valid; the accepting edge
// moves to the exec state and the result is registered out of it. The receiver
// cannot stall: results must be taken when shown.
// Each beat is one synchronous read of the entry and tag rams at the accepting
// edge, then compare, write back and counter update in the exec state; the next
// beat may enter at the edge that ends the result cycle. After reset, and after
// a clear that wraps the generation counter, busy stays high while the tag ram
// is swept to zero over every entry, one entry per cycle (the wrap result is
// shown in the first sweep cycle). Counts in a result are the saturating
// counters after that beat's action.

module generation_tagged_memo_cache_unit
  import gtmc_pkg::*;
#(
  parameter int INDEX_BITS = 12,
  parameter int GEN_BITS   = 8
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    start,
  output logic    busy,
  input  action_t in_action,
  input  key_t    in_key,
  input  value_t  in_fill_value,
  output logic    out_valid,
  output logic    out_hit,
  output value_t  out_cached_value,
  output count_t  out_probe_count,
  output count_t  out_hit_count,
  output count_t  out_store_count
);

  localparam int DATA_W = KEY_W + VAL_W;

  typedef enum logic [1:0] {ST_IDLE, ST_EXEC, ST_SWEEP} state_t;

  typedef logic [GEN_BITS-1:0]   gen_t;
  typedef logic [INDEX_BITS-1:0] index_t;

  localparam gen_t GEN_ONE = gen_t'(1);

  state_t  state_r, state_nxt;
  gen_t    gen_r, gen_nxt;
  index_t  sweep_r, sweep_nxt;
  action_t act_r;
  key_t    key_r;
  value_t  fval_r;
  logic    out_valid_r, out_valid_nxt;
  logic    hit_r, hit_nxt;
  value_t  cval_r, cval_nxt;

  logic              accept;
  logic [DATA_W-1:0] data_rd;
  gen_t              tag_rd;
  logic              data_we, tag_we;
  index_t            tag_waddr;
  gen_t              tag_wdata;
  logic              probe_hit;
  gen_t              gen_inc;
  stat_op_t          stat_op;

  assign accept = start && (state_r == ST_IDLE);
  assign busy   = (state_r != ST_IDLE);

  // read both rams at the beat's slot on the accepting edge
  gtmc_ram #(.ADDR_BITS(INDEX_BITS), .WIDTH(DATA_W)) u_data_ram (
    .clk   (clk),
    .we    (data_we),
    .waddr (key_r[INDEX_BITS-1:0]),
    .wdata ({key_r, fval_r}),
    .raddr (in_key[INDEX_BITS-1:0]),
    .rdata (data_rd)
  );

  gtmc_ram #(.ADDR_BITS(INDEX_BITS), .WIDTH(GEN_BITS)) u_tag_ram (
    .clk   (clk),
    .we    (tag_we),
    .waddr (tag_waddr),
    .wdata (tag_wdata),
    .raddr (in_key[INDEX_BITS-1:0]),
    .rdata (tag_rd)
  );

  // write back happens at the end of the exec cycle, before the next read
  assign data_we   = (state_r == ST_EXEC) && (act_r == ACT_FILL);
  assign tag_we    = data_we || (state_r == ST_SWEEP);
  assign tag_waddr = (state_r == ST_SWEEP) ? sweep_r : key_r[INDEX_BITS-1:0];
  assign tag_wdata = (state_r == ST_SWEEP) ? '0 : gen_r;

  assign probe_hit = (act_r == ACT_PROBE) && (tag_rd == gen_r)
                     && (data_rd[DATA_W-1:VAL_W] == key_r);
  assign gen_inc   = gen_r + GEN_ONE;

  always_comb begin
    stat_op       = '0;
    if (state_r == ST_EXEC) begin
      stat_op.probe = (act_r == ACT_PROBE);
      stat_op.hit   = probe_hit;
      stat_op.fill  = (act_r == ACT_FILL);
      stat_op.clear = (act_r == ACT_CLEAR);
    end
  end

  gtmc_stats u_stats (
    .clk         (clk),
    .rst_n       (rst_n),
    .op          (stat_op),
    .probe_count (out_probe_count),
    .hit_count   (out_hit_count),
    .store_count (out_store_count)
  );

  always_comb begin
    state_nxt     = state_r;
    gen_nxt       = gen_r;
    sweep_nxt     = sweep_r;
    out_valid_nxt = 1'b0;
    hit_nxt       = 1'b0;
    cval_nxt      = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (start) state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        out_valid_nxt = 1'b1;
        hit_nxt       = probe_hit;
        cval_nxt      = probe_hit ? data_rd[VAL_W-1:0] : '0;
        state_nxt     = ST_IDLE;
        if (act_r == ACT_CLEAR) begin
          // wrap to zero: sweep every tag and restart at one
          if (gen_inc == '0) begin
            gen_nxt   = GEN_ONE;
            sweep_nxt = '0;
            state_nxt = ST_SWEEP;
          end else begin
            gen_nxt = gen_inc;
          end
        end
      end
      ST_SWEEP: begin
        sweep_nxt = sweep_r + index_t'(1);
        if (sweep_r == '1) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_SWEEP;
      gen_r       <= GEN_ONE;
      sweep_r     <= '0;
      out_valid_r <= 1'b0;
      hit_r       <= 1'b0;
      cval_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      gen_r       <= gen_nxt;
      sweep_r     <= sweep_nxt;
      out_valid_r <= out_valid_nxt;
      hit_r       <= hit_nxt;
      cval_r      <= cval_nxt;
    end
  end

  // beat payload capture
  always_ff @(posedge clk) begin
    if (accept) begin
      act_r  <= in_action;
      key_r  <= in_key;
      fval_r <= in_fill_value;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_hit          = hit_r;
  assign out_cached_value = cval_r;

  // a result follows exactly one exec cycle
  a_result_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(state_r == ST_EXEC))
    else $error("result without a preceding exec cycle");

  // a hit only comes from a probe
  a_hit_only_probe: assert property (@(posedge clk) disable iff (!rst_n)
    out_hit |-> out_valid && $past(act_r == ACT_PROBE))
    else $error("hit reported for a non-probe beat");

  // the generation never holds the reserved zero tag
  a_gen_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    gen_r != '0)
    else $error("generation reached zero");

  // no fill write may land during a tag sweep
  a_no_fill_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SWEEP) |-> !data_we && (tag_wdata == '0))
    else $error("fill write during tag sweep");

  // a miss carries a zero value
  a_miss_zero_value: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_hit) |-> (out_cached_value == '0))
    else $error("nonzero value on a miss");

endmodule

/* hdl/gtmc_ram.sv */
// gtmc_ram: simple dual-port synchronous ram, one write and one registered read
// depends on nothing; used for the entry data and the entry tags
`timescale 1ns / 1ps

module gtmc_ram #(
  parameter int ADDR_BITS = 12,
  parameter int WIDTH     = 8
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [ADDR_BITS-1:0] waddr,
  input  logic [WIDTH-1:0]     wdata,
  input  logic [ADDR_BITS-1:0] raddr,
  output logic [WIDTH-1:0]     rdata
);

  logic [WIDTH-1:0] mem [2**ADDR_BITS];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* hdl/gtmc_stats.sv */
// gtmc_stats: saturating probe, hit and store counters, zeroed by a clear
// depends on gtmc_pkg
`timescale 1ns / 1ps

module gtmc_stats
  import gtmc_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  stat_op_t op,
  output count_t   probe_count,
  output count_t   hit_count,
  output count_t   store_count
);

  count_t probe_r, probe_nxt;
  count_t hit_r, hit_nxt;
  count_t store_r, store_nxt;

  function automatic count_t sat_inc(input count_t c);
    return (c == COUNT_MAX) ? c : c + count_t'(1);
  endfunction

  always_comb begin
    probe_nxt = probe_r;
    hit_nxt   = hit_r;
    store_nxt = store_r;
    priority if (op.clear) begin
      probe_nxt = '0;
      hit_nxt   = '0;
      store_nxt = '0;
    end else begin
      if (op.probe) probe_nxt = sat_inc(probe_r);
      if (op.hit)   hit_nxt   = sat_inc(hit_r);
      if (op.fill)  store_nxt = sat_inc(store_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      probe_r <= '0;
      hit_r   <= '0;
      store_r <= '0;
    end else begin
      probe_r <= probe_nxt;
      hit_r   <= hit_nxt;
      store_r <= store_nxt;
    end
  end

  assign probe_count = probe_r;
  assign hit_count   = hit_r;
  assign store_count = store_r;

endmodule

/* tb/gtmc_checker.sv */
// gtmc_checker: result predictor and scoreboard for the memo cache
// depends on gtmc_pkg; sits beside generation_tagged_memo_cache_unit in tb
`timescale 1ns / 1ps

module gtmc_checker
  import gtmc_pkg::*;
#(
  parameter int INDEX_BITS = 12,
  parameter int GEN_BITS   = 8
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    start,
  input  logic    busy,
  input  action_t in_action,
  input  key_t    in_key,
  input  value_t  in_fill_value,
  input  logic    out_valid,
  input  logic    out_hit,
  input  value_t  out_cached_value,
  input  count_t  out_probe_count,
  input  count_t  out_hit_count,
  input  count_t  out_store_count,
  output int      fail_count,
  output int      outstanding,
  output int      checked_count,
  output int      wrap_count
);

  localparam int ENTRIES = 1 << INDEX_BITS;

  typedef logic [GEN_BITS-1:0] gen_t;

  typedef struct packed {
    logic   hit;
    value_t value;
    count_t probes;
    count_t hits;
    count_t stores;
  } memo_result_t;

  key_t   memo_key [ENTRIES];
  value_t memo_val [ENTRIES];
  gen_t   memo_tag [ENTRIES];
  gen_t   generation;
  count_t probes_n;
  count_t hits_n;
  count_t stores_n;

  memo_result_t due_results[$];
  int fails;
  int checked;
  int wraps;

  function automatic count_t bump(count_t c);
    return (c == COUNT_MAX) ? c : c + 1'b1;
  endfunction

  // applies one beat to the cache image and returns the result it must give
  function automatic memo_result_t memo_step(action_t act, key_t key, value_t val);
    memo_result_t          r;
    logic [INDEX_BITS-1:0] slot;
    r = '0;
    slot = key[INDEX_BITS-1:0];
    case (act)
      ACT_PROBE: begin
        probes_n = bump(probes_n);
        if (memo_tag[slot] == generation && memo_key[slot] == key) begin
          hits_n = bump(hits_n);
          r.hit = 1'b1;
          r.value = memo_val[slot];
        end
      end
      ACT_FILL: begin
        memo_key[slot] = key;
        memo_val[slot] = val;
        memo_tag[slot] = generation;
        stores_n = bump(stores_n);
      end
      ACT_CLEAR: begin
        generation = generation + 1'b1;
        if (generation == '0) begin
          foreach (memo_tag[i]) memo_tag[i] = '0;
          generation = gen_t'(1);
          wraps++;
        end
        probes_n = '0;
        hits_n = '0;
        stores_n = '0;
      end
      default: ;
    endcase
    r.probes = probes_n;
    r.hits = hits_n;
    r.stores = stores_n;
    return r;
  endfunction

  function automatic void check_field(string field, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      fails++;
      $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
    end
  endfunction

  always @(posedge clk) begin
    memo_result_t want;
    if (!rst_n) begin
      foreach (memo_tag[i]) memo_tag[i] = '0;
      generation = gen_t'(1);
      probes_n = '0;
      hits_n = '0;
      stores_n = '0;
      due_results.delete();
    end else begin
      // a result seen at this edge always belongs to an older beat
      if (out_valid) begin
        if (due_results.size() == 0) begin
          fails++;
          $display("%0t ns: unexpected result, expected none, actual hit %b value %0h",
                   $time, out_hit, out_cached_value);
        end else begin
          want = due_results.pop_front();
          checked++;
          check_field("hit", 32'(want.hit), 32'(out_hit));
          check_field("cached_value", 32'(want.value), 32'(out_cached_value));
          check_field("probe_count", want.probes, out_probe_count);
          check_field("hit_count", want.hits, out_hit_count);
          check_field("store_count", want.stores, out_store_count);
        end
      end
      if (start && !busy)
        due_results = {due_results, memo_step(in_action, in_key, in_fill_value)};
    end
    fail_count <= fails;
    outstanding <= due_results.size();
    checked_count <= checked;
    wrap_count <= wraps;
  end

endmodule

/* tb/tb.sv */
// tb: stimulus and verdict for generation_tagged_memo_cache_unit
// depends on gtmc_pkg, the block's rtl and gtmc_checker
`timescale 1ns / 1ps

module tb;
  import gtmc_pkg::*;

  localparam int INDEX_BITS   = 12;
  localparam int GEN_BITS     = 8;
  localparam int ENTRIES      = 1 << INDEX_BITS;
  localparam int RANDOM_BEATS = 1200;
  localparam int HOT_SLOTS    = 64;
  // window of beats sent back to back, no sender gaps
  localparam int QUIET_FIRST  = 400;
  localparam int QUIET_LAST   = 700;
  // beat count after which the long run of clears forces a generation wrap
  localparam int STORM_AT     = 600;

  // action code 3 is not defined by the block and must change nothing
  localparam action_t ACT_UNUSED = 2'd3;

  logic    clk = 1'b0;
  logic    rst_n = 1'b0;
  logic    start = 1'b0;
  action_t in_action = ACT_PROBE;
  key_t    in_key = '0;
  value_t  in_fill_value = '0;

  logic    busy;
  logic    out_valid;
  logic    out_hit;
  value_t  out_cached_value;
  count_t  out_probe_count;
  count_t  out_hit_count;
  count_t  out_store_count;

  int fail_count;
  int outstanding;
  int checked_count;
  int wrap_count;

  // stimulus bookkeeping: which slots hold a written key, and the last key there
  bit   written [ENTRIES];
  int   written_slots[$];
  key_t last_key [ENTRIES];

  int n_probe;
  int n_fill;
  int n_clear;
  int n_unused;
  int beat_no;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  generation_tagged_memo_cache_unit #(
    .INDEX_BITS(INDEX_BITS),
    .GEN_BITS  (GEN_BITS)
  ) u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_action       (in_action),
    .in_key          (in_key),
    .in_fill_value   (in_fill_value),
    .out_valid       (out_valid),
    .out_hit         (out_hit),
    .out_cached_value(out_cached_value),
    .out_probe_count (out_probe_count),
    .out_hit_count   (out_hit_count),
    .out_store_count (out_store_count)
  );

  gtmc_checker #(
    .INDEX_BITS(INDEX_BITS),
    .GEN_BITS  (GEN_BITS)
  ) u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_action       (in_action),
    .in_key          (in_key),
    .in_fill_value   (in_fill_value),
    .out_valid       (out_valid),
    .out_hit         (out_hit),
    .out_cached_value(out_cached_value),
    .out_probe_count (out_probe_count),
    .out_hit_count   (out_hit_count),
    .out_store_count (out_store_count),
    .fail_count      (fail_count),
    .outstanding     (outstanding),
    .checked_count   (checked_count),
    .wrap_count      (wrap_count)
  );

  // present one beat and hold it until the block takes it; called at a
  // rising edge (or time zero), returns at the edge that accepted the beat
  // or after a random sender gap
  task automatic send_beat(action_t act, key_t key, value_t val);
    int slot;
    in_action <= act;
    in_key <= key;
    in_fill_value <= val;
    start <= 1'b1;
    // busy read here is the value before the edge, so the test matches the block's
    do @(posedge clk); while (busy);
    slot = int'(key[INDEX_BITS-1:0]);
    case (act)
      ACT_PROBE: n_probe++;
      ACT_FILL: begin
        n_fill++;
        last_key[slot] = key;
        if (!written[slot]) begin
          written[slot] = 1'b1;
          written_slots = {written_slots, slot};
        end
      end
      ACT_CLEAR: n_clear++;
      default: n_unused++;
    endcase
    beat_no++;
    // about 7 in 100 beats are followed by a gap, except in the quiet window;
    // gaps land on both the exec cycle and the result cycle of the block's beat
    if (!(beat_no >= QUIET_FIRST && beat_no < QUIET_LAST) && $urandom_range(0, 99) < 7) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  // random key whose index bits select the given slot
  function automatic key_t key_for_slot(int slot);
    key_t k;
    k = {$urandom, $urandom};
    k[INDEX_BITS-1:0] = slot[INDEX_BITS-1:0];
    return k;
  endfunction

  // fills mostly go to a small hot set of slots so later probes find them
  task automatic do_fill();
    int   slot;
    key_t k;
    slot = ($urandom_range(0, 3) != 0) ? $urandom_range(0, HOT_SLOTS - 1)
                                       : $urandom_range(0, ENTRIES - 1);
    // sometimes rewrite the same key with a fresh value
    if (written[slot] && $urandom_range(0, 99) < 30)
      k = last_key[slot];
    else
      k = key_for_slot(slot);
    send_beat(ACT_FILL, k, value_t'($urandom));
  endtask

  // probes only touch slots that were written, since unwritten content is
  // undefined; most use the stored key, the rest a different key on that slot
  task automatic do_probe();
    int   slot;
    key_t k;
    slot = written_slots[$urandom_range(0, written_slots.size() - 1)];
    k = ($urandom_range(0, 99) < 75) ? last_key[slot] : key_for_slot(slot);
    send_beat(ACT_PROBE, k, value_t'($urandom));
  endtask

  // clear and the unused code ignore the key; keep it on a written slot anyway
  task automatic do_other(action_t act);
    int slot;
    slot = written_slots[$urandom_range(0, written_slots.size() - 1)];
    send_beat(act, key_for_slot(slot), value_t'($urandom));
  endtask

  initial begin
    int pick;
    int directed_beats;
    int guard;
    bit stormed;
    stormed = 1'b0;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // directed beats: field extremes, hit and miss on one slot, replacement,
    // the unused code, and stale entries after a clear
    send_beat(ACT_FILL, 64'h0, 16'h7fff);
    send_beat(ACT_FILL, {64{1'b1}}, 16'h8000);
    send_beat(ACT_PROBE, 64'h0, 16'hffff);
    send_beat(ACT_PROBE, {64{1'b1}}, 16'h0);
    // same slot, different key: miss
    send_beat(ACT_PROBE, 64'h8000_0000_0000_0000, 16'h0);
    // replace slot 0 with the other key, old key must now miss
    send_beat(ACT_FILL, 64'h8000_0000_0000_0000, 16'h0);
    send_beat(ACT_PROBE, 64'h0, 16'h0);
    send_beat(ACT_PROBE, 64'h8000_0000_0000_0000, 16'h0);
    // unused code leaves counters and entries alone
    send_beat(ACT_UNUSED, {64{1'b1}}, 16'hffff);
    send_beat(ACT_PROBE, {64{1'b1}}, 16'h0);
    send_beat(ACT_FILL, 64'h0123_4567_89ab_cdef, 16'hffff);
    send_beat(ACT_PROBE, 64'h0123_4567_89ab_cdef, 16'h0);
    // clear: counts restart and every entry goes stale
    send_beat(ACT_CLEAR, {64{1'b1}}, 16'h0);
    send_beat(ACT_PROBE, 64'h0123_4567_89ab_cdef, 16'h0);
    send_beat(ACT_PROBE, 64'h8000_0000_0000_0000, 16'h0);
    // refill after the clear, hit twice
    send_beat(ACT_FILL, 64'h0123_4567_89ab_cdef, 16'h1234);
    send_beat(ACT_PROBE, 64'h0123_4567_89ab_cdef, 16'h0);
    send_beat(ACT_PROBE, 64'h0123_4567_89ab_cdef, 16'h0);
    send_beat(ACT_FILL, 64'hffff_ffff_ffff_f000, 16'h8000);
    send_beat(ACT_PROBE, 64'hffff_ffff_ffff_f000, 16'h0);
    directed_beats = beat_no;

    // random part, built from short sequences
    while (beat_no < directed_beats + RANDOM_BEATS) begin
      pick = $urandom_range(0, 99);
      if (!stormed && beat_no >= STORM_AT) begin
        // long run of 255 clears: wraps the generation at least once, with
        // probes in between that must miss on entries written many clears ago
        stormed = 1'b1;
        for (int i = 0; i < 272; i++) begin
          if (i % 16 == 15) do_probe();
          else do_other(ACT_CLEAR);
        end
      end else if (pick < 70) begin
        // well-formed: a few fills, then probes that mostly hit
        repeat ($urandom_range(1, 6)) do_fill();
        repeat ($urandom_range(2, 10)) do_probe();
      end else if (pick < 85) begin
        // noise: any action in any order
        repeat ($urandom_range(3, 8)) begin
          case ($urandom_range(0, 3))
            0: do_probe();
            1: do_fill();
            2: do_other(ACT_CLEAR);
            default: do_other(ACT_UNUSED);
          endcase
        end
      end else if (pick < 95) begin
        // clear followed by probes of stale entries
        do_other(ACT_CLEAR);
        repeat ($urandom_range(2, 6)) do_probe();
      end else begin
        // burst of clears that moves the generation along quickly
        repeat ($urandom_range(20, 60)) begin
          if ($urandom_range(0, 99) < 85) do_other(ACT_CLEAR);
          else do_probe();
        end
      end
    end

    start <= 1'b0;

    // drain: wait until every predicted result has been compared
    guard = 0;
    do begin
      @(negedge clk);
      guard++;
    end while (outstanding != 0 && guard < 20000);
    if (outstanding != 0) begin
      $display("%0t ns: %0d results never arrived", $time, outstanding);
      $display("CHECK FAILED");
      $finish;
    end else begin
      // keep running so a stray extra result would still be caught
      repeat (10) @(negedge clk);
      $display("covered %0d beats: %0d probes, %0d fills, %0d clears, %0d unused-code",
               beat_no, n_probe, n_fill, n_clear, n_unused);
      $display("%0d results compared, %0d generation wraps, %0d slots written",
               checked_count, wrap_count, written_slots.size());
      if (fail_count == 0 && outstanding == 0) begin
        $display("CHECK OK");
      end else begin
        $display("CHECK FAILED");
      end
      $finish;
    end
  end

  // watchdog: far beyond the slowest correct run, tag sweeps included
  initial begin
    #400000;
    $display("%0t ns: run did not finish in time", $time);
    $display("CHECK FAILED");
    $finish;
  end

endmodule
